### rtl/rpap_pkg.sv
// Shared constants, register indexes and coefficient functions for the
// radial power alpha pixel block. No dependencies.
package rpap_pkg;

	localparam int MAX_DIM  = 4096;
	localparam int DIM_W    = 13;
	localparam int COORD_W  = 12;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W    = 16;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_OFFSET = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FALLOFF_EXP  = 3'd4;

	localparam int DIV_LAT   = 16;
	localparam int SQRT_LAT  = 16;
	localparam int LOG_LAT   = 16;
	localparam int EXP_LAT   = 16;
	localparam int POW_LAT   = SQRT_LAT + 1 + LOG_LAT + 1 + EXP_LAT + 1;
	localparam int TOTAL_LAT = 1 + DIV_LAT + 2 + POW_LAT + 3;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bitv;
		logic [63:0] rem;
		res  = '0;
		rem  = v;
		bitv = 64'h4000_0000_0000_0000;
		for (int i = 0; i < 32; i++) begin
			if (bitv > rem)
				bitv = bitv >> 2;
		end
		for (int i = 0; i < 32; i++) begin
			if (bitv != 0) begin
				if (rem >= res + bitv) begin
					rem = rem - (res + bitv);
					res = (res >> 1) + bitv;
				end else begin
					res = res >> 1;
				end
				bitv = bitv >> 2;
			end
		end
		return res;
	endfunction

	// 2^(2^-(k+1)) in Q.30, built by repeated square roots
	function automatic logic [30:0] exp_coef(input int k);
		logic [63:0] c;
		c = isqrt64(64'h2000_0000_0000_0000);
		for (int j = 1; j < 16; j++) begin
			if (j <= k)
				c = isqrt64(c << 30);
		end
		return c[30:0];
	endfunction

endpackage

### rtl/rpap_div.sv
// Pipelined restoring divider: (num << 16) / den, one quotient bit per stage.
// Saturates to all ones when num >= den. Uses rpap_pkg.
module rpap_div (
	input  logic                       clk,
	input  logic                       en,
	input  logic [rpap_pkg::COORD_W-1:0] num,
	input  logic [rpap_pkg::DIM_W-1:0]   den,
	output logic [15:0]                quo
);
	import rpap_pkg::*;

	logic [DIM_W-1:0] rem_s [0:DIV_LAT];
	logic [15:0]      quo_s [0:DIV_LAT];
	logic             sat_s [0:DIV_LAT];

	assign rem_s[0] = DIM_W'(num);
	assign quo_s[0] = '0;
	assign sat_s[0] = (DIM_W'(num) >= den);

	for (genvar k = 0; k < DIV_LAT; k++) begin : g_stage
		logic [DIM_W-1:0] dbl;
		logic             take;
		assign dbl  = {rem_s[k][DIM_W-2:0], 1'b0};
		assign take = (dbl >= den);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= take ? dbl - den : dbl;
				quo_s[k+1] <= {quo_s[k][14:0], take};
				sat_s[k+1] <= sat_s[k];
			end
		end
	end

	assign quo = sat_s[DIV_LAT] ? 16'hFFFF : quo_s[DIV_LAT];

endmodule

### rtl/rpap_pow.sv
// Radius power unit: integer square root, log2 by repeated squaring, scale by
// the exponent and exp2 by coefficient products, all pipelined. Uses rpap_pkg.
module rpap_pow (
	input  logic               clk,
	input  logic               en,
	input  logic [31:0]        rad_sq,
	input  logic signed [15:0] expo,
	output logic [31:0]        pw
);
	import rpap_pkg::*;

	// square root
	logic [17:0] sq_rem_s  [0:SQRT_LAT];
	logic [15:0] sq_root_s [0:SQRT_LAT];
	logic [31:0] sq_v_s    [0:SQRT_LAT];

	assign sq_rem_s[0]  = '0;
	assign sq_root_s[0] = '0;
	assign sq_v_s[0]    = rad_sq;

	for (genvar i = 0; i < SQRT_LAT; i++) begin : g_sqrt
		logic [19:0] rem4;
		logic [19:0] trial;
		logic        take;
		assign rem4  = {sq_rem_s[i], sq_v_s[i][31:30]};
		assign trial = {2'b00, sq_root_s[i], 2'b01};
		assign take  = (rem4 >= trial);
		always_ff @(posedge clk) begin
			if (en) begin
				sq_rem_s[i+1]  <= take ? 18'(rem4 - trial) : rem4[17:0];
				sq_root_s[i+1] <= {sq_root_s[i][14:0], take};
				sq_v_s[i+1]    <= {sq_v_s[i][29:0], 2'b00};
			end
		end
	end

	// leading one and normalize
	logic [15:0] rad;
	logic [3:0]  lead;
	logic [3:0]  lz_p_s1;
	logic [15:0] lz_m_s1;
	logic        lz_z_s1;

	assign rad = sq_root_s[SQRT_LAT];

	always_comb begin
		lead = '0;
		for (int i = 0; i < 16; i++) begin
			if (rad[i])
				lead = 4'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lz_p_s1 <= lead;
			lz_m_s1 <= 16'(rad << (4'd15 - lead));
			lz_z_s1 <= (rad == 16'd0);
		end
	end

	// log2 fraction
	logic [15:0] lg_m_s [0:LOG_LAT];
	logic [15:0] lg_f_s [0:LOG_LAT];
	logic [3:0]  lg_p_s [0:LOG_LAT];
	logic        lg_z_s [0:LOG_LAT];

	assign lg_m_s[0] = lz_m_s1;
	assign lg_f_s[0] = '0;
	assign lg_p_s[0] = lz_p_s1;
	assign lg_z_s[0] = lz_z_s1;

	for (genvar i = 0; i < LOG_LAT; i++) begin : g_log
		logic [31:0] sq;
		logic [16:0] sh;
		assign sq = lg_m_s[i] * lg_m_s[i];
		assign sh = sq[31:15];
		always_ff @(posedge clk) begin
			if (en) begin
				lg_m_s[i+1] <= sh[16] ? sh[16:1] : sh[15:0];
				lg_f_s[i+1] <= {lg_f_s[i][14:0], sh[16]};
				lg_p_s[i+1] <= lg_p_s[i];
				lg_z_s[i+1] <= lg_z_s[i];
			end
		end
	end

	// scale by exponent
	logic signed [20:0] lval;
	logic signed [36:0] em_s1;
	logic               em_z_s1;

	assign lval = {1'b1, lg_p_s[LOG_LAT], lg_f_s[LOG_LAT]};

	always_ff @(posedge clk) begin
		if (en) begin
			em_s1   <= expo * lval;
			em_z_s1 <= lg_z_s[LOG_LAT];
		end
	end

	// exp2 of the fraction
	logic [31:0]        ex_m_s [0:EXP_LAT];
	logic [15:0]        ex_f_s [0:EXP_LAT];
	logic signed [12:0] ex_i_s [0:EXP_LAT];
	logic               ex_z_s [0:EXP_LAT];

	assign ex_m_s[0] = 32'h4000_0000;
	assign ex_f_s[0] = em_s1[23:8];
	assign ex_i_s[0] = em_s1[36:24];
	assign ex_z_s[0] = em_z_s1;

	for (genvar k = 0; k < EXP_LAT; k++) begin : g_exp
		localparam logic [30:0] COEF = exp_coef(k);
		logic [61:0] prod;
		assign prod = 62'(ex_m_s[k]) * 62'(COEF);
		always_ff @(posedge clk) begin
			if (en) begin
				ex_m_s[k+1] <= ex_f_s[k][15-k] ? prod[61:30] : ex_m_s[k];
				ex_f_s[k+1] <= ex_f_s[k];
				ex_i_s[k+1] <= ex_i_s[k];
				ex_z_s[k+1] <= ex_z_s[k];
			end
		end
	end

	// integer part and special cases
	logic signed [12:0] ip;
	logic [31:0]        mant;
	logic signed [13:0] rdist;
	logic [31:0]        pw_next;
	logic [31:0]        pw_s1;

	assign ip    = ex_i_s[EXP_LAT];
	assign mant  = ex_m_s[EXP_LAT];
	assign rdist = 14'sd14 - 14'(ip);

	always_comb begin
		if (ex_z_s[EXP_LAT]) begin
			if (expo > 16'sd0)
				pw_next = '0;
			else if (expo == 16'sd0)
				pw_next = 32'h0001_0000;
			else
				pw_next = '1;
		end else if (ip >= 13'sd16) begin
			pw_next = '1;
		end else if (ip < -13'sd17) begin
			pw_next = '0;
		end else if (ip <= 13'sd13) begin
			pw_next = mant >> rdist[4:0];
		end else begin
			pw_next = mant << ip[0];
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			pw_s1 <= pw_next;
	end

	assign pw = pw_s1;

endmodule

### rtl/radial_power_alpha_pixel.sv
// Radial power alpha pixel: passes RGB through and adds a radial alpha byte.
// Accepts one pixel per cycle while the output is not stalled.
// The whole pipeline advances together and holds while the output is stalled.
// Asynchronous active-low reset clears the valid bits and loads the register
// defaults (256x256 frame, gain 1.0, offset 0, exponent 1.0).
module radial_power_alpha_pixel (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [rpap_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rpap_pkg::CFG_W-1:0]     cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // pix_col, pix_row, in_red, in_green, in_blue
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // out_red, out_green, out_blue, out_alpha
);
	import rpap_pkg::*;

	logic [DIM_W-1:0] fw_q;
	logic [DIM_W-1:0] fh_q;
	logic [15:0]      gain_q;
	logic [15:0]      off_q;
	logic [15:0]      exp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q   <= 13'd256;
			fh_q   <= 13'd256;
			gain_q <= 16'd256;
			off_q  <= '0;
			exp_q  <= 16'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  fw_q   <= cfg_data[DIM_W-1:0];
				REG_FRAME_HEIGHT: fh_q   <= cfg_data[DIM_W-1:0];
				REG_GAIN:         gain_q <= cfg_data;
				REG_LEVEL_OFFSET: off_q  <= cfg_data;
				REG_FALLOFF_EXP:  exp_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	logic en;
	logic vld_s [0:TOTAL_LAT-1];
	logic [23:0] rgb_s [0:TOTAL_LAT-1];

	assign en       = !vld_s[TOTAL_LAT-1] || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TOTAL_LAT; i++)
				vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= s_tvalid;
			for (int i = 1; i < TOTAL_LAT; i++)
				vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rgb_s[0] <= s_tdata[47:24];
			for (int i = 1; i < TOTAL_LAT; i++)
				rgb_s[i] <= rgb_s[i-1];
		end
	end

	// centre the coordinates
	logic [COORD_W-1:0] col_s1;
	logic [COORD_W-1:0] row_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			col_s1 <= s_tdata[11:0];
			row_s1 <= s_tdata[23:12];
		end
	end

	logic [DIM_W-1:0]   wc;
	logic [DIM_W-1:0]   hc;
	logic [COORD_W-1:0] cx;
	logic [COORD_W-1:0] cy;
	logic [COORD_W-1:0] ax;
	logic [COORD_W-1:0] ay;

	assign wc = (fw_q < 13'd2) ? 13'd2 : (fw_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : fw_q;
	assign hc = (fh_q < 13'd2) ? 13'd2 : (fh_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : fh_q;
	assign cx = wc[DIM_W-1:1];
	assign cy = hc[DIM_W-1:1];
	assign ax = (col_s1 >= cx) ? col_s1 - cx : cx - col_s1;
	assign ay = (row_s1 >= cy) ? row_s1 - cy : cy - row_s1;

	logic [15:0] xn;
	logic [15:0] yn;

	rpap_div u_div_x (.clk(clk), .en(en), .num(ax), .den(wc), .quo(xn));
	rpap_div u_div_y (.clk(clk), .en(en), .num(ay), .den(hc), .quo(yn));

	logic [31:0] xx_s18;
	logic [31:0] yy_s18;
	logic [32:0] sqsum;
	logic [31:0] v_s19;

	assign sqsum = {1'b0, xx_s18} + {1'b0, yy_s18};

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s18 <= xn * xn;
			yy_s18 <= yn * yn;
			v_s19  <= sqsum[32] ? 32'hFFFF_FFFF : sqsum[31:0];
		end
	end

	logic [31:0] pw;

	rpap_pow u_pow (
		.clk   (clk),
		.en    (en),
		.rad_sq(v_s19),
		.expo  (signed'(exp_q)),
		.pw    (pw)
	);

	// scale, offset and convert to a byte
	logic signed [48:0] prod_s71;
	logic signed [49:0] ssum;
	logic signed [57:0] q255;
	logic signed [57:0] q_s72;
	logic signed [57:0] qadj;
	logic [7:0]         alpha_s73;

	assign ssum = 50'(prod_s71) + (50'(signed'(off_q)) <<< 16);
	assign q255 = (58'(ssum) <<< 8) - 58'(ssum);
	assign qadj = q_s72[57] ? q_s72 + 58'(24'hFF_FFFF) : q_s72;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s71  <= signed'(gain_q) * signed'({1'b0, pw});
			q_s72     <= q255;
			alpha_s73 <= qadj[31:24];
		end
	end

	assign m_tvalid = vld_s[TOTAL_LAT-1];
	assign m_tdata  = {alpha_s73, rgb_s[TOTAL_LAT-1]};

endmodule

### rtl/rpap_check.sv
// Port-level checker for radial_power_alpha_pixel and its bind statement.
// Uses only the top-level ports.
module rpap_check (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output changed while stalled");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with empty output");

	a_ready_drain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input blocked while output drains");

	a_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input transfer taken while output stalled");

endmodule

bind radial_power_alpha_pixel rpap_check u_rpap_check (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
